FILE: rtl/tmac_pkg.sv
// Package for the triangle minimum-angle check: payload structs, codes, state enums
// and the fixed arithmetic widths. Used by every module of the block.
package tmac_pkg;

  localparam int unsigned NODE_IDX_W = 12;
  localparam int unsigned FIELD_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned EDGE_W     = 33;
  localparam int unsigned MUL_W      = 35;
  localparam int unsigned PROD_W     = 70;
  localparam int unsigned LIMB_W     = 34;
  localparam int unsigned SUM_W      = 68;
  localparam int unsigned T_W        = 3 * LIMB_W;
  localparam int unsigned R_W        = 4 * LIMB_W;
  localparam int unsigned L_W        = 5 * LIMB_W;
  localparam int unsigned COS_SHIFT  = 30;

  typedef enum logic [0:0] {
    ACT_WRITE_NODE = 1'b0,
    ACT_CHECK_FACE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CFG_CHECK_ENABLE = 2'd0,
    CFG_MARK_ALL     = 2'd1,
    CFG_COS_LIMIT    = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_PASS    = 2'd0,
    ST_MARKED  = 2'd1,
    ST_STOPPED = 2'd2
  } status_e;

  typedef struct packed {
    action_e                 action;
    logic [NODE_IDX_W-1:0]   node_index;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic [NODE_IDX_W-1:0]   vertex_a_index;
    logic [NODE_IDX_W-1:0]   vertex_b_index;
    logic [NODE_IDX_W-1:0]   vertex_c_index;
    logic                    last_face;
  } in_t;

  typedef struct packed {
    logic    face_bad;
    logic    run_done;
    status_e status;
  } out_t;

  typedef struct packed {
    logic               check_enable;
    logic               mark_all_faces;
    logic signed [31:0] cos_limit_signed_square;
  } cfg_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pa;
    logic [2:0][COORD_W-1:0] pb;
    logic [2:0][COORD_W-1:0] pc;
    logic                    last_face;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RD_A,
    F_RD_B,
    F_RD_C,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EDGE,
    B_SUM,
    B_CORNER,
    B_DONE
  } back_state_e;

endpackage

FILE: rtl/tmac_front.sv
// Front part: accepts requests, writes node coordinates into the node store and
// fetches the three corner nodes of each face. Depends on tmac_pkg.
module tmac_front #(
  parameter int NODE_COUNT = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tmac_pkg::in_t   face_i,
  input  logic            push,
  output logic            full,
  output tmac_pkg::job_t  job_o,
  output logic            job_push_o,
  input  logic            job_full_i
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NW = 3 * COORD_BITS;

  tmac_pkg::front_state_e state_q, state_d;

  logic [NW-1:0] mem [NODE_COUNT];
  logic [NW-1:0] rd_q;
  logic          rd_ok_q;
  logic [tmac_pkg::NODE_IDX_W-1:0] ia_q, ib_q, ic_q, rd_idx;
  logic          last_q;
  logic [2:0][tmac_pkg::COORD_W-1:0] pa_q, pb_q;
  logic          accept, wr_en;
  logic [NW-1:0] wdata;

  function automatic logic in_range(input logic [tmac_pkg::NODE_IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [tmac_pkg::NODE_IDX_W-1:0] idx);
    return AW'({{AW{1'b0}}, idx});
  endfunction

  function automatic logic [COORD_BITS-1:0] to_coord(input logic [tmac_pkg::FIELD_W-1:0] f);
    return COORD_BITS'({{COORD_BITS{1'b0}}, f});
  endfunction

  function automatic logic [2:0][tmac_pkg::COORD_W-1:0] unpack_node(input logic [NW-1:0] raw,
                                                                     input logic ok);
    logic signed [COORD_BITS-1:0] c;
    logic [2:0][tmac_pkg::COORD_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      c = raw[k*COORD_BITS +: COORD_BITS];
      r[k] = ok ? tmac_pkg::COORD_W'(c) : '0;
    end
    return r;
  endfunction

  assign full   = (state_q != tmac_pkg::F_IDLE);
  assign accept = push && !full;
  assign wr_en  = accept && (face_i.action == tmac_pkg::ACT_WRITE_NODE) &&
                  in_range(face_i.node_index);
  assign wdata  = {to_coord(face_i.coord_z), to_coord(face_i.coord_y),
                   to_coord(face_i.coord_x)};

  always_comb begin
    state_d = state_q;
    case (state_q)
      tmac_pkg::F_IDLE: begin
        if (accept && face_i.action == tmac_pkg::ACT_CHECK_FACE) begin
          state_d = tmac_pkg::F_RD_A;
        end
      end
      tmac_pkg::F_RD_A: state_d = tmac_pkg::F_RD_B;
      tmac_pkg::F_RD_B: state_d = tmac_pkg::F_RD_C;
      tmac_pkg::F_RD_C: state_d = tmac_pkg::F_PUSH;
      tmac_pkg::F_PUSH: begin
        if (!job_full_i) begin
          state_d = tmac_pkg::F_IDLE;
        end
      end
      default: state_d = tmac_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    rd_idx     = ia_q;
    job_push_o = 1'b0;
    case (state_q)
      tmac_pkg::F_RD_B: rd_idx = ib_q;
      tmac_pkg::F_RD_C: rd_idx = ic_q;
      tmac_pkg::F_PUSH: begin
        rd_idx     = ic_q;
        job_push_o = !job_full_i;
      end
      default: rd_idx = ia_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmac_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[to_addr(face_i.node_index)] <= wdata;
    end
    rd_q <= mem[to_addr(rd_idx)];
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= in_range(rd_idx);
    if (accept) begin
      ia_q   <= face_i.vertex_a_index;
      ib_q   <= face_i.vertex_b_index;
      ic_q   <= face_i.vertex_c_index;
      last_q <= face_i.last_face;
    end
    if (state_q == tmac_pkg::F_RD_B) begin
      pa_q <= unpack_node(rd_q, rd_ok_q);
    end
    if (state_q == tmac_pkg::F_RD_C) begin
      pb_q <= unpack_node(rd_q, rd_ok_q);
    end
  end

  assign job_o.pa        = pa_q;
  assign job_o.pb        = pb_q;
  assign job_o.pc        = unpack_node(rd_q, rd_ok_q);
  assign job_o.last_face = last_q;

endmodule

FILE: rtl/tmac_queue.sv
// Two-entry queue of fetched face requests between the front and back parts.
// Depends on tmac_pkg for the request struct.
module tmac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmac_pkg::job_t wr_data_i,
  input  logic           wr_i,
  output logic           full_o,
  output tmac_pkg::job_t rd_data_o,
  output logic           valid_o,
  input  logic           rd_i
);

  tmac_pkg::job_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign rd_data_o = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) begin
        wp_q <= !wp_q;
      end
      if (rd_i) begin
        rp_q <= !rp_q;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wp_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/tmac_back.sv
// Back part: forms edges, squared lengths and dot products on one shared 35x35
// multiplier, compares each corner exactly in 34-bit limbs and keeps the run status.
// Depends on tmac_pkg.
module tmac_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmac_pkg::cfg_t cfg_i,
  input  tmac_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  output tmac_pkg::out_t res_o,
  output logic           res_valid_o,
  input  logic           res_pop_i
);

  localparam int unsigned LW = tmac_pkg::LIMB_W;
  localparam int unsigned SW = tmac_pkg::SUM_W;

  typedef enum logic [1:0] {
    ACC_T,
    ACC_R,
    ACC_L
  } acc_sel_e;

  tmac_pkg::back_state_e state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [1:0] comp_q, comp_d;
  logic [1:0] corner_q, corner_d;

  logic signed [tmac_pkg::EDGE_W-1:0] e_q [3][3];
  logic signed [SW-1:0] sum_q [6];
  logic signed [tmac_pkg::PROD_W-1:0] prod_q;
  logic        pv_q, psum_q, pneg_q;
  logic [2:0]  pdest_q;
  logic [1:0]  poff_q;
  logic [tmac_pkg::T_W-1:0] t_q;
  logic [tmac_pkg::R_W-1:0] r_q;
  logic [tmac_pkg::L_W-1:0] l_q;
  logic        bad_q, err_q;
  tmac_pkg::out_t out_q;
  logic        out_valid_q;

  logic        iss, iss_neg, iss_sum, out_free, out_wr, done_corner;
  logic [2:0]  iss_dest;
  logic [1:0]  iss_off;
  logic signed [tmac_pkg::MUL_W-1:0] opa, opb;
  logic [LW-1:0] la_u, lb_u;
  logic [1:0]  ea, eb;
  logic [2:0]  lai, lbi, di;
  logic [2*LW-1:0] la_v, lb_v, dmag;
  logic signed [SW-1:0] dv;
  logic [31:0] cmag;
  logic        cneg, dneg, dzero, corner_bad, any_zero, skip, err_new;
  logic [tmac_pkg::L_W-1:0] pp_sh, right_v;
  tmac_pkg::status_e status_v;

  assign out_free    = !out_valid_q || res_pop_i;
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;
  assign skip        = err_q && !cfg_i.mark_all_faces;
  assign done_corner = (state_q == tmac_pkg::B_CORNER) && (step_q == 4'd13);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    comp_d   = comp_q;
    corner_d = corner_q;
    case (state_q)
      tmac_pkg::B_IDLE: begin
        if (job_valid_i) begin
          if (skip && !job_i.last_face) begin
            state_d = tmac_pkg::B_IDLE;
          end else if (!skip && cfg_i.check_enable) begin
            state_d = tmac_pkg::B_EDGE;
          end else begin
            state_d = tmac_pkg::B_DONE;
          end
        end
      end
      tmac_pkg::B_EDGE: begin
        state_d = tmac_pkg::B_SUM;
        step_d  = 4'd0;
        comp_d  = 2'd0;
      end
      tmac_pkg::B_SUM: begin
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          if (step_q == 4'd5) begin
            state_d  = tmac_pkg::B_CORNER;
            step_d   = 4'd0;
            corner_d = 2'd0;
          end else begin
            step_d = step_q + 4'd1;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      tmac_pkg::B_CORNER: begin
        if (step_q == 4'd13) begin
          step_d = 4'd0;
          if (corner_q == 2'd2) begin
            state_d = tmac_pkg::B_DONE;
          end else begin
            corner_d = corner_q + 2'd1;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      tmac_pkg::B_DONE: begin
        if (out_free) begin
          state_d = tmac_pkg::B_IDLE;
        end
      end
      default: state_d = tmac_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    out_wr    = 1'b0;
    case (state_q)
      tmac_pkg::B_IDLE: job_pop_o = job_valid_i && skip && !job_i.last_face;
      tmac_pkg::B_DONE: begin
        job_pop_o = out_free;
        out_wr    = out_free;
      end
      default: job_pop_o = 1'b0;
    endcase
  end

  always_comb begin
    ea      = 2'd0;
    eb      = 2'd0;
    iss_neg = 1'b0;
    case (step_q)
      4'd0: begin ea = 2'd0; eb = 2'd0; end
      4'd1: begin ea = 2'd1; eb = 2'd1; end
      4'd2: begin ea = 2'd2; eb = 2'd2; end
      4'd3: begin ea = 2'd0; eb = 2'd1; end
      4'd4: begin ea = 2'd0; eb = 2'd2; iss_neg = 1'b1; end
      4'd5: begin ea = 2'd2; eb = 2'd1; end
      default: begin ea = 2'd0; eb = 2'd0; end
    endcase
  end

  always_comb begin
    case (corner_q)
      2'd1:    begin lai = 3'd0; lbi = 3'd2; di = 3'd4; end
      2'd2:    begin lai = 3'd2; lbi = 3'd1; di = 3'd5; end
      default: begin lai = 3'd0; lbi = 3'd1; di = 3'd3; end
    endcase
    la_v = (2*LW)'(sum_q[lai]);
    lb_v = (2*LW)'(sum_q[lbi]);
    dv   = sum_q[di];
    dmag = dv[SW-1] ? (2*LW)'(-dv) : (2*LW)'(dv);
    cneg = cfg_i.cos_limit_signed_square[31];
    cmag = cneg ? 32'(-cfg_i.cos_limit_signed_square) : 32'(cfg_i.cos_limit_signed_square);
  end

  always_comb begin
    la_u     = '0;
    lb_u     = '0;
    iss_dest = 3'(ACC_T);
    iss_off  = 2'd0;
    case (step_q)
      4'd0:  begin la_u = LW'(cmag); lb_u = la_v[LW-1:0]; end
      4'd1:  begin la_u = LW'(cmag); lb_u = la_v[2*LW-1:LW]; iss_off = 2'd1; end
      4'd2:  begin la_u = dmag[LW-1:0]; lb_u = dmag[LW-1:0]; iss_dest = 3'(ACC_R); end
      4'd3:  begin
        la_u = dmag[LW-1:0]; lb_u = dmag[2*LW-1:LW]; iss_dest = 3'(ACC_R); iss_off = 2'd1;
      end
      4'd4:  begin
        la_u = dmag[2*LW-1:LW]; lb_u = dmag[LW-1:0]; iss_dest = 3'(ACC_R); iss_off = 2'd1;
      end
      4'd5:  begin
        la_u = dmag[2*LW-1:LW]; lb_u = dmag[2*LW-1:LW]; iss_dest = 3'(ACC_R); iss_off = 2'd2;
      end
      4'd6:  begin la_u = t_q[LW-1:0]; lb_u = lb_v[LW-1:0]; iss_dest = 3'(ACC_L); end
      4'd7:  begin
        la_u = t_q[LW-1:0]; lb_u = lb_v[2*LW-1:LW]; iss_dest = 3'(ACC_L); iss_off = 2'd1;
      end
      4'd8:  begin
        la_u = t_q[2*LW-1:LW]; lb_u = lb_v[LW-1:0]; iss_dest = 3'(ACC_L); iss_off = 2'd1;
      end
      4'd9:  begin
        la_u = t_q[2*LW-1:LW]; lb_u = lb_v[2*LW-1:LW]; iss_dest = 3'(ACC_L); iss_off = 2'd2;
      end
      4'd10: begin
        la_u = t_q[3*LW-1:2*LW]; lb_u = lb_v[LW-1:0]; iss_dest = 3'(ACC_L); iss_off = 2'd2;
      end
      4'd11: begin
        la_u = t_q[3*LW-1:2*LW]; lb_u = lb_v[2*LW-1:LW]; iss_dest = 3'(ACC_L);
        iss_off = 2'd3;
      end
      default: begin la_u = '0; lb_u = '0; end
    endcase
  end

  always_comb begin
    iss_sum = (state_q == tmac_pkg::B_SUM);
    iss     = iss_sum || ((state_q == tmac_pkg::B_CORNER) && (step_q < 4'd12));
    if (iss_sum) begin
      opa = tmac_pkg::MUL_W'(e_q[ea][comp_q]);
      opb = tmac_pkg::MUL_W'(e_q[eb][comp_q]);
    end else begin
      opa = $signed({1'b0, la_u});
      opb = $signed({1'b0, lb_u});
    end
  end

  always_comb begin
    pp_sh   = tmac_pkg::L_W'(prod_q[2*LW-1:0]) << (LW * poff_q);
    right_v = tmac_pkg::L_W'({r_q, {tmac_pkg::COS_SHIFT{1'b0}}});
    dneg    = dv[SW-1];
    dzero   = (dv == '0);
    if (!cneg) begin
      if (dneg) begin
        corner_bad = 1'b1;
      end else if (dzero) begin
        corner_bad = (cmag != 32'd0);
      end else begin
        corner_bad = (l_q > right_v);
      end
    end else begin
      corner_bad = dneg && (l_q < right_v);
    end
    any_zero = (sum_q[0] == '0) || (sum_q[1] == '0) || (sum_q[2] == '0);
    err_new  = err_q || bad_q;
    status_v = tmac_pkg::ST_PASS;
    if (job_i.last_face && err_new) begin
      status_v = cfg_i.mark_all_faces ? tmac_pkg::ST_MARKED : tmac_pkg::ST_STOPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmac_pkg::B_IDLE;
      step_q      <= 4'd0;
      comp_q      <= 2'd0;
      corner_q    <= 2'd0;
      pv_q        <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      comp_q   <= comp_d;
      corner_q <= corner_d;
      pv_q     <= iss;
      if (out_wr) begin
        err_q       <= job_i.last_face ? 1'b0 : err_new;
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= opa * opb;
    psum_q  <= iss_sum;
    pneg_q  <= iss_neg;
    pdest_q <= iss_sum ? step_q[2:0] : iss_dest;
    poff_q  <= iss_off;
    if (state_q == tmac_pkg::B_IDLE) begin
      bad_q <= 1'b0;
    end else if (done_corner) begin
      bad_q <= bad_q || corner_bad || ((corner_q == 2'd2) && any_zero);
    end
    if (out_wr) begin
      out_q.face_bad <= bad_q;
      out_q.run_done <= job_i.last_face;
      out_q.status   <= status_v;
    end
    if (state_q == tmac_pkg::B_EDGE) begin
      for (int k = 0; k < 3; k++) begin
        e_q[0][k] <= tmac_pkg::EDGE_W'(signed'(job_i.pb[k])) -
                     tmac_pkg::EDGE_W'(signed'(job_i.pa[k]));
        e_q[1][k] <= tmac_pkg::EDGE_W'(signed'(job_i.pc[k])) -
                     tmac_pkg::EDGE_W'(signed'(job_i.pa[k]));
        e_q[2][k] <= tmac_pkg::EDGE_W'(signed'(job_i.pc[k])) -
                     tmac_pkg::EDGE_W'(signed'(job_i.pb[k]));
      end
      for (int s = 0; s < 6; s++) begin
        sum_q[s] <= '0;
      end
    end else if (pv_q && psum_q) begin
      if (pneg_q) begin
        sum_q[pdest_q] <= sum_q[pdest_q] - SW'(prod_q);
      end else begin
        sum_q[pdest_q] <= sum_q[pdest_q] + SW'(prod_q);
      end
    end
    if ((state_q == tmac_pkg::B_CORNER) && (step_q == 4'd0)) begin
      t_q <= '0;
      r_q <= '0;
      l_q <= '0;
    end else if (pv_q && !psum_q) begin
      case (acc_sel_e'(pdest_q[1:0]))
        ACC_T:   t_q <= t_q + tmac_pkg::T_W'(pp_sh);
        ACC_R:   r_q <= r_q + tmac_pkg::R_W'(pp_sh);
        ACC_L:   l_q <= l_q + pp_sh;
        default: l_q <= l_q;
      endcase
    end
  end

endmodule

FILE: rtl/triangle_min_angle_check.sv
// Top level of the triangle minimum-angle check: configuration registers and the
// front part, request queue and back part. Depends on tmac_pkg and all tmac modules.
//
// Usage: the input side is a queue. An item is taken when push is high and full low.
// Action write-node stores one node's coordinates; it gives no result. Action
// check-face fetches its three nodes from the node store, then waits in a two-entry
// queue for the back part. The back part takes one checked face at a time: it picks
// up the request, forms the edges, issues 18 multiplications for the squared lengths
// and dot products, runs an exact limb compare for each corner, and posts the result;
// all of it shares the 35x35 multiplier.
// A face that is not checked (check off, or dropped after a bad face) skips the edge,
// sum and corner steps.
// Results wait in an output register: empty low shows one, pop takes it. When the
// receiver stalls, the back part holds its finished face and the queue fills, after
// which full stays high. Reset empties the queue and the output, clears the run
// status and the registers; node contents are undefined until written, no sweep.
// Configuration writes are always ready and must only happen while the block is idle.
module triangle_min_angle_check #(
  parameter int NODE_COUNT = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmac_pkg::in_t                     face_i,
  input  logic                              push,
  output logic                              full,
  output tmac_pkg::out_t                    result_o,
  output logic                              empty,
  input  logic                              pop,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tmac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  tmac_pkg::cfg_t cfg_q;
  tmac_pkg::job_t fr_job, q_job;
  logic fr_push, q_full, q_valid, q_pop, res_valid;

  assign cfg_ready_o = 1'b1;
  assign empty       = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tmac_pkg::cfg_index_e'(cfg_index_i))
        tmac_pkg::CFG_CHECK_ENABLE: cfg_q.check_enable <= cfg_data_i[0];
        tmac_pkg::CFG_MARK_ALL:     cfg_q.mark_all_faces <= cfg_data_i[0];
        tmac_pkg::CFG_COS_LIMIT:    cfg_q.cos_limit_signed_square <= $signed(cfg_data_i);
        default:                    cfg_q <= cfg_q;
      endcase
    end
  end

  tmac_front #(
    .NODE_COUNT(NODE_COUNT),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .face_i     (face_i),
    .push       (push),
    .full       (full),
    .job_o      (fr_job),
    .job_push_o (fr_push),
    .job_full_i (q_full)
  );

  tmac_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (fr_job),
    .wr_i      (fr_push),
    .full_o    (q_full),
    .rd_data_o (q_job),
    .valid_o   (q_valid),
    .rd_i      (q_pop)
  );

  tmac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .res_o       (result_o),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

endmodule

FILE: test/tb.sv
// Testbench for triangle_min_angle_check: node writes and face checks with random idling.
// Predicts each face verdict with exact wide integer arithmetic. Depends on tmac_pkg.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  tmac_pkg::in_t face_i = '0;
  logic push = 1'b0;
  logic full;
  tmac_pkg::out_t result_o;
  logic empty;
  logic pop = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tmac_pkg::CFG_IDX_W-1:0] cfg_index_i = tmac_pkg::CFG_CHECK_ENABLE;
  logic [31:0] cfg_data_i = '0;

  triangle_min_angle_check uut (.*);

  always #5 clk_i = ~clk_i;

  tmac_pkg::in_t request_q[$];
  tmac_pkg::out_t verdict_q[$];
  logic signed [23:0] node_x[4096];
  logic signed [23:0] node_y[4096];
  logic signed [23:0] node_z[4096];
  int written_q[$];
  logic written[4096];
  logic en_cfg = 1'b0;
  logic mark_cfg = 1'b0;
  logic signed [31:0] cos_cfg = '0;
  logic run_error = 1'b0;
  int errors = 0;
  int phase = 0;
  logic quiet = 1'b0;
  logic hold_done = 1'b0;

  function automatic logic corner_bad(logic signed [199:0] lu, logic signed [199:0] lv,
                                      logic signed [199:0] d);
    logic signed [199:0] c;
    logic signed [199:0] lhs;
    logic signed [199:0] rhs;
    c = cos_cfg;
    lhs = c * lu * lv;
    rhs = (d * (d < 0 ? -d : d)) <<< 30;
    return lhs > rhs;
  endfunction

  function automatic logic face_is_bad(int ia, int ib, int ic);
    logic signed [199:0] e1[3];
    logic signed [199:0] e2[3];
    logic signed [199:0] e3[3];
    logic signed [199:0] l1, l2, l3, d12, d13, d32;
    logic signed [199:0] pa[3];
    logic signed [199:0] pb[3];
    logic signed [199:0] pc[3];
    pa = '{node_x[ia], node_y[ia], node_z[ia]};
    pb = '{node_x[ib], node_y[ib], node_z[ib]};
    pc = '{node_x[ic], node_y[ic], node_z[ic]};
    l1 = 0; l2 = 0; l3 = 0; d12 = 0; d13 = 0; d32 = 0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = pb[k] - pa[k];
      e2[k] = pc[k] - pa[k];
      e3[k] = pc[k] - pb[k];
      l1 += e1[k] * e1[k];
      l2 += e2[k] * e2[k];
      l3 += e3[k] * e3[k];
      d12 += e1[k] * e2[k];
      d13 -= e1[k] * e3[k];
      d32 += e3[k] * e2[k];
    end
    if (l1 == 0 || l2 == 0 || l3 == 0) return 1'b1;
    return corner_bad(l1, l2, d12) || corner_bad(l1, l3, d13) || corner_bad(l3, l2, d32);
  endfunction

  task automatic predict_request(tmac_pkg::in_t req);
    tmac_pkg::out_t res;
    logic bad;
    bad = 1'b0;
    if (req.action == tmac_pkg::ACT_WRITE_NODE) begin
      node_x[req.node_index] = req.coord_x;
      node_y[req.node_index] = req.coord_y;
      node_z[req.node_index] = req.coord_z;
      return;
    end
    if (run_error && !mark_cfg && !req.last_face) return;
    if (!run_error || mark_cfg) begin
      if (en_cfg) bad = face_is_bad(req.vertex_a_index, req.vertex_b_index,
                                    req.vertex_c_index);
      if (bad) run_error = 1'b1;
    end
    res.face_bad = bad;
    res.run_done = req.last_face;
    res.status = tmac_pkg::ST_PASS;
    if (req.last_face) begin
      if (run_error) res.status = mark_cfg ? tmac_pkg::ST_MARKED : tmac_pkg::ST_STOPPED;
      run_error = 1'b0;
    end
    verdict_q.push_back(res);
  endtask

  function automatic tmac_pkg::in_t noise_request();
    tmac_pkg::in_t r;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(tmac_pkg::in_t)-1:0];
    return r;
  endfunction

  task automatic add_node(int idx, int x, int y, int z);
    tmac_pkg::in_t r;
    r = noise_request();
    r.action = tmac_pkg::ACT_WRITE_NODE;
    r.node_index = 12'(idx);
    r.coord_x = 24'(x);
    r.coord_y = 24'(y);
    r.coord_z = 24'(z);
    if (!written[idx]) written_q.push_back(idx);
    written[idx] = 1'b1;
    request_q.push_back(r);
  endtask

  task automatic add_face(int a, int b, int c, logic last);
    tmac_pkg::in_t r;
    r = noise_request();
    r.action = tmac_pkg::ACT_CHECK_FACE;
    r.vertex_a_index = 12'(a);
    r.vertex_b_index = 12'(b);
    r.vertex_c_index = 12'(c);
    r.last_face = last;
    request_q.push_back(r);
  endtask

  task automatic write_reg(tmac_pkg::cfg_index_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      tmac_pkg::CFG_CHECK_ENABLE: en_cfg = data[0];
      tmac_pkg::CFG_MARK_ALL: mark_cfg = data[0];
      default: cos_cfg = data;
    endcase
  endtask

  task automatic drain();
    while (request_q.size() != 0 || verdict_q.size() != 0 || push) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int base, a, b, c;
    logic signed [23:0] bx, by, bz;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          base = $urandom_range(4093);
          bx = 24'($urandom); by = 24'($urandom); bz = 24'($urandom);
          for (int k = 0; k < 3; k++)
            add_node(base + k, bx + int'($urandom_range(4000)) - 2000,
                     by + int'($urandom_range(4000)) - 2000,
                     bz + int'($urandom_range(40)) - 20);
          add_face(base, base + 1, ($urandom_range(15) == 0) ? base : base + 2,
                   $urandom_range(5) == 0);
          i += 3;
        end
        4: add_node($urandom_range(4095), $urandom, $urandom, $urandom);
        default: begin
          a = written_q[$urandom_range(written_q.size() - 1)];
          b = written_q[$urandom_range(written_q.size() - 1)];
          c = written_q[$urandom_range(written_q.size() - 1)];
          add_face(a, b, c, $urandom_range(7) == 0);
        end
      endcase
    end
  endtask

  // Driver: offers queued requests and predicts each accepted one.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (push && !full) begin
      predict_request(request_q.pop_front());
    end
    if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      push <= 1'b0;
    end else if (!quiet && push && $urandom_range(9) == 0) begin
      send_gap <= $urandom_range(15);
      push <= 1'b0;
    end else if (request_q.size() > 0) begin
      push <= 1'b1;
      face_i <= request_q[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor: pops results with random stalls and checks them in order.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    tmac_pkg::out_t want;
    if (pop && !empty) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p, expected none", $time, result_o);
      end else begin
        want = verdict_q.pop_front();
        if (result_o.face_bad !== want.face_bad) begin
          errors++;
          $display("%0t: face_bad expected %b actual %b", $time, want.face_bad,
                   result_o.face_bad);
        end
        if (result_o.run_done !== want.run_done) begin
          errors++;
          $display("%0t: run_done expected %b actual %b", $time, want.run_done,
                   result_o.run_done);
        end
        if (result_o.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result_o.status);
        end
      end
    end
    if (!hold_done && phase == 2 && verdict_q.size() > 0) begin
      hold_done <= 1'b1;
      recv_gap <= 2000;
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      pop <= 1'b0;
    end else if (!quiet && pop && $urandom_range(9) == 0) begin
      recv_gap <= $urandom_range(15);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int ph;
    logic [31:0] limits[8];
    logic ens[8];
    logic marks[8];
    for (int i = 0; i < 4096; i++) written[i] = 1'b0;
    limits = '{32'd0, 32'd536870912, 32'd536870912, 32'hC0000000,
               32'd1073741824, 32'h80000000, 32'd0, 32'd805306368};
    ens = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    marks = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < 8; ph++) begin
      limits[6] = $urandom;
      write_reg(tmac_pkg::CFG_CHECK_ENABLE, {31'd0, ens[ph]});
      write_reg(tmac_pkg::CFG_MARK_ALL, {31'd0, marks[ph]});
      write_reg(tmac_pkg::CFG_COS_LIMIT, limits[ph]);
      phase = ph;
      if (ph == 1) begin
        add_node(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        add_node(4095, -24'sh800000, -24'sh800000, -24'sh800000);
        add_node(1, 24'sh7FFFFF, -24'sh800000, 0);
        add_node(2, 0, 0, 0);
        add_node(3, 1000, 0, 0);
        add_node(4, 0, 1000, 0);
        add_node(5, 500, 866, 0);
        add_node(6, 1000000, 1, 0);
        add_face(2, 3, 4, 1'b0);
        add_face(2, 3, 5, 1'b0);
        add_face(2, 2, 3, 1'b0);
        add_face(2, 3, 6, 1'b0);
        add_face(0, 4095, 1, 1'b0);
        add_face(2, 3, 4, 1'b1);
        add_face(2, 3, 6, 1'b0);
        add_face(2, 3, 5, 1'b0);
        add_face(2, 3, 4, 1'b1);
      end
      if (ph == 7) quiet = 1'b1;
      if (written_q.size() == 0) add_node(7, 0, 0, 0);
      random_items(130);
      drain();
    end
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
